/* rtl/apsp_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the all-pairs shortest path core: request codes,
// result kinds, register map and field widths. No dependencies.
package apsp_pkg;

    // Default sizing of the cost store.
    localparam int MAX_VERTICES_DEF = 64;
    localparam int DIST_WIDTH_DEF   = 16;

    // Field widths of the request and result channels.
    localparam int FUNC_W     = 2;
    localparam int INDEX_W    = 6;
    localparam int WEIGHT_W   = 16;
    localparam int DISTANCE_W = 16;
    localparam int VIA_W      = 7;

    // Register file.
    localparam int VC_W       = 7;
    localparam int NP_W       = 16;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_NO_PATH      = 1'b1;
    localparam logic [VC_W-1:0] VC_RESET = 7'd0;
    localparam logic [NP_W-1:0] NP_RESET = 16'd999;

    // Request codes.
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Result kinds.
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

endpackage

/* rtl/apsp_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module apsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/apsp_relax.sv */
`timescale 1ns / 1ps
// Shared relaxation unit: saturating add of two path costs, compare against
// the stored cost, registered write-back request. No package dependencies.
module apsp_relax #(
    parameter int DIST_WIDTH = 16,
    parameter int AW         = 12,
    parameter int VW         = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [DIST_WIDTH-1:0] ik,
    input  logic [DIST_WIDTH-1:0] kj,
    input  logic [DIST_WIDTH-1:0] ij,
    input  logic [AW-1:0]         in_addr,
    input  logic [VW-1:0]         in_via,
    output logic                  we,
    output logic [AW-1:0]         waddr,
    output logic [DIST_WIDTH-1:0] wcost,
    output logic [VW-1:0]         wvia
);

    logic [DIST_WIDTH:0]   sum;
    logic [DIST_WIDTH-1:0] sat;
    logic                  better;
    logic                  we_reg;
    logic [AW-1:0]         waddr_reg;
    logic [DIST_WIDTH-1:0] wcost_reg;
    logic [VW-1:0]         wvia_reg;

    assign sum    = {1'b0, ik} + {1'b0, kj};
    assign sat    = sum[DIST_WIDTH] ? {DIST_WIDTH{1'b1}} : sum[DIST_WIDTH-1:0];
    assign better = sat < ij;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            we_reg <= 1'b0;
        end else begin
            we_reg <= in_valid && better;
        end
        waddr_reg <= in_addr;
        wcost_reg <= sat;
        wvia_reg  <= in_via;
    end

    assign we    = we_reg;
    assign waddr = waddr_reg;
    assign wcost = wcost_reg;
    assign wvia  = wvia_reg;

endmodule

/* rtl/all_pairs_shortest_path_core.sv */
`timescale 1ns / 1ps
// Top level of the all-pairs shortest path core: request decode, run
// sequencer, register file. Uses apsp_pkg, apsp_ram and apsp_relax.
//
// All-pairs shortest path engine (Floyd-Warshall) over a cost matrix of
// MAX_VERTICES x MAX_VERTICES entries held in on-chip RAM, with a parallel
// via matrix that records the last improving intermediate vertex (1 based,
// 0 for a direct edge). After reset the core runs a clearing pass over all
// 2**(2*clog2(MAX_VERTICES)) RAM entries (4096 by default) that loads 999
// off the diagonal and 0 on it; no request is taken during that pass,
// register writes are. A write request gives no result. A read request returns
// distance and via vertex (kind 0). A run request uses n = min(vertex_count,
// MAX_VERTICES) and returns one result of kind 1 with zero payload. The run
// time is set by the single shared add/saturate/compare unit, which relaxes
// one (i,j) pair per cycle; each row adds a fetch of the (i,k) cost and each
// k pass a drain of the write-back pipeline. Sums saturate at the all-ones
// DIST_WIDTH value, and the no-path marker is an ordinary cost during
// relaxation. Requests whose row or col is not below MAX_VERTICES are
// ignored on write and read back as zero. Registers: vertex_count at 0x0,
// no_path_value at 0x4 (the latter is read back only; the clearing pass
// always uses the reset value).
module all_pairs_shortest_path_core #(
    parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF,
    parameter int DIST_WIDTH   = apsp_pkg::DIST_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [apsp_pkg::PADDR_W-1:0]     paddr,
    input  logic [apsp_pkg::PDATA_W-1:0]     pwdata,
    output logic [apsp_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    // request channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [apsp_pkg::FUNC_W-1:0]      s_func,
    input  logic [apsp_pkg::INDEX_W-1:0]     s_row,
    input  logic [apsp_pkg::INDEX_W-1:0]     s_col,
    input  logic [apsp_pkg::WEIGHT_W-1:0]    s_weight,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_kind,
    output logic [apsp_pkg::DISTANCE_W-1:0]  m_distance,
    output logic [apsp_pkg::VIA_W-1:0]       m_via_vertex
);

    import apsp_pkg::*;

    localparam int IW    = $clog2(MAX_VERTICES);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int VW    = $clog2(MAX_VERTICES + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // ------------------------------------------------------------------
    // Register file: user must write only while the core is idle; not enforced.
    // ------------------------------------------------------------------
    logic [VC_W-1:0] vc_reg;
    logic [NP_W-1:0] np_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= VC_RESET;
            np_reg <= NP_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_VERTEX_COUNT: vc_reg <= pwdata[VC_W-1:0];
                REG_NO_PATH:      np_reg <= pwdata[NP_W-1:0];
                default:          vc_reg <= vc_reg;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NO_PATH) ? PDATA_W'(np_reg) : PDATA_W'(vc_reg);

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    state_t                state_reg,     state_next;
    logic [IW-1:0]         k_reg,         k_next;
    logic [IW-1:0]         i_reg,         i_next;
    logic [IW-1:0]         j_reg,         j_next;
    logic [IW-1:0]         last_reg,      last_next;
    logic                  drain_reg,     drain_next;
    logic [AW-1:0]         clr_addr_reg,  clr_addr_next;
    logic                  ik_load_reg,   ik_load_next;
    logic [DIST_WIDTH-1:0] ik_reg,        ik_next;
    logic                  iss_v_reg,     iss_v_next;
    logic [AW-1:0]         iss_addr_reg,  iss_addr_next;
    logic                  rd_inside_reg, rd_inside_next;
    logic                  m_valid_reg,   m_valid_next;
    logic                  m_kind_reg,    m_kind_next;
    logic [DISTANCE_W-1:0] m_dist_reg,    m_dist_next;
    logic [VIA_W-1:0]      m_via_reg,     m_via_next;

    logic                  accept;
    logic                  in_inside;
    logic [AW-1:0]         in_addr;
    int                    run_n;

    // RAM ports
    logic                  cost_we;
    logic [AW-1:0]         cost_waddr;
    logic [DIST_WIDTH-1:0] cost_wdata;
    logic                  via_we;
    logic [AW-1:0]         via_waddr;
    logic [VW-1:0]         via_wdata;
    logic [AW-1:0]         raddr_a;
    logic [AW-1:0]         raddr_b;
    logic [DIST_WIDTH-1:0] cost_a_rdata;
    logic [DIST_WIDTH-1:0] cost_b_rdata;
    logic [VW-1:0]         via_rdata;

    // relaxation unit
    logic                  relax_we;
    logic [AW-1:0]         relax_waddr;
    logic [DIST_WIDTH-1:0] relax_wcost;
    logic [VW-1:0]         relax_wvia;

    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign in_inside = (32'(s_row) < MAX_VERTICES) && (32'(s_col) < MAX_VERTICES);
    assign in_addr   = {IW'(s_row), IW'(s_col)};
    assign run_n     = (32'(vc_reg) > MAX_VERTICES) ? MAX_VERTICES : 32'(vc_reg);

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        last_next      = last_reg;
        drain_next     = drain_reg;
        clr_addr_next  = clr_addr_reg;
        ik_load_next   = 1'b0;
        ik_next        = ik_load_reg ? cost_a_rdata : ik_reg;
        iss_v_next     = 1'b0;
        iss_addr_next  = {i_reg, j_reg};
        rd_inside_next = rd_inside_reg;
        // drop the held result once the sink takes it
        m_valid_next   = m_valid_reg && !m_ready;
        m_kind_next    = m_kind_reg;
        m_dist_next    = m_dist_reg;
        m_via_next     = m_via_reg;

        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_func)
                        FUNC_RUN: begin
                            k_next     = '0;
                            i_next     = '0;
                            j_next     = '0;
                            drain_next = 1'b0;
                            if (run_n == 0) begin
                                state_next = ST_DONE;
                            end else begin
                                last_next  = IW'(run_n - 1);
                                state_next = ST_FETCH;
                            end
                        end
                        FUNC_READ: begin
                            rd_inside_next = in_inside;
                            state_next     = ST_READ;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                m_kind_next  = KIND_READ;
                m_dist_next  = rd_inside_reg ? DISTANCE_W'(cost_a_rdata) : '0;
                m_via_next   = rd_inside_reg ? VIA_W'(via_rdata) : '0;
                state_next   = ST_IDLE;
            end
            ST_FETCH: begin
                // cost(i,k) is fixed for the whole k pass; latch it once per row
                ik_load_next = 1'b1;
                j_next       = '0;
                state_next   = ST_SWEEP;
            end
            ST_SWEEP: begin
                iss_v_next = 1'b1;
                if (j_reg == last_reg) begin
                    if (i_reg == last_reg) begin
                        drain_next = 1'b0;
                        state_next = ST_DRAIN;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                // hold until the last write-back of this pass has landed
                drain_next = 1'b1;
                if (drain_reg) begin
                    if (k_reg == last_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        i_next     = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_DONE: begin
                m_valid_next = 1'b1;
                m_kind_next  = KIND_RUN;
                m_dist_next  = '0;
                m_via_next   = '0;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            drain_reg    <= 1'b0;
            ik_load_reg  <= 1'b0;
            iss_v_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            drain_reg    <= drain_next;
            ik_load_reg  <= ik_load_next;
            iss_v_reg    <= iss_v_next;
            m_valid_reg  <= m_valid_next;
        end
        k_reg         <= k_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        last_reg      <= last_next;
        ik_reg        <= ik_next;
        iss_addr_reg  <= iss_addr_next;
        rd_inside_reg <= rd_inside_next;
        m_kind_reg    <= m_kind_next;
        m_dist_reg    <= m_dist_next;
        m_via_reg     <= m_via_next;
    end

    // ------------------------------------------------------------------
    // RAM address and write selection
    // ------------------------------------------------------------------
    always_comb begin
        raddr_a = in_addr;
        raddr_b = {i_reg, j_reg};
        case (state_reg)
            ST_FETCH: raddr_a = {i_reg, k_reg};
            ST_SWEEP: raddr_a = {k_reg, j_reg};
            default:  raddr_a = in_addr;
        endcase
    end

    always_comb begin
        cost_we    = 1'b0;
        cost_waddr = relax_waddr;
        cost_wdata = relax_wcost;
        via_we     = 1'b0;
        via_waddr  = relax_waddr;
        via_wdata  = relax_wvia;
        if (state_reg == ST_CLEAR) begin
            // zero on the diagonal, no-path marker elsewhere
            cost_we    = 1'b1;
            cost_waddr = clr_addr_reg;
            cost_wdata = (clr_addr_reg[AW-1:IW] == clr_addr_reg[IW-1:0]) ?
                         '0 : DIST_WIDTH'(NP_RESET);
            via_we     = 1'b1;
            via_waddr  = clr_addr_reg;
            via_wdata  = '0;
        end else if (relax_we) begin
            cost_we = 1'b1;
            via_we  = 1'b1;
        end else if (accept && (s_func == FUNC_WRITE) && in_inside) begin
            // an edge load leaves the via entry untouched
            cost_we    = 1'b1;
            cost_waddr = in_addr;
            cost_wdata = DIST_WIDTH'(s_weight);
        end
    end

    // Two copies of the cost matrix give the two reads a relaxation needs.
    apsp_ram #(
        .WIDTH (DIST_WIDTH),
        .DEPTH (DEPTH)
    ) u_cost_a (
        .aclk  (aclk),
        .we    (cost_we),
        .waddr (cost_waddr),
        .wdata (cost_wdata),
        .raddr (raddr_a),
        .rdata (cost_a_rdata)
    );

    apsp_ram #(
        .WIDTH (DIST_WIDTH),
        .DEPTH (DEPTH)
    ) u_cost_b (
        .aclk  (aclk),
        .we    (cost_we),
        .waddr (cost_waddr),
        .wdata (cost_wdata),
        .raddr (raddr_b),
        .rdata (cost_b_rdata)
    );

    apsp_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_via (
        .aclk  (aclk),
        .we    (via_we),
        .waddr (via_waddr),
        .wdata (via_wdata),
        .raddr (in_addr),
        .rdata (via_rdata)
    );

    apsp_relax #(
        .DIST_WIDTH (DIST_WIDTH),
        .AW         (AW),
        .VW         (VW)
    ) u_relax (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (iss_v_reg),
        .ik       (ik_reg),
        .kj       (cost_a_rdata),
        .ij       (cost_b_rdata),
        .in_addr  (iss_addr_reg),
        .in_via   (VW'(32'(k_reg) + 1)),
        .we       (relax_we),
        .waddr    (relax_waddr),
        .wcost    (relax_wcost),
        .wvia     (relax_wvia)
    );

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_distance   = m_dist_reg;
    assign m_via_vertex = m_via_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_run_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_RUN)) |-> ((m_distance == '0) && (m_via_vertex == '0)))
        else $error("run result carries a nonzero payload");

    a_relax_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        relax_we |-> ((state_reg == ST_FETCH) || (state_reg == ST_SWEEP) ||
                      (state_reg == ST_DRAIN)))
        else $error("relaxation write-back outside a run pass");

    a_run_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_func == FUNC_RUN)) |=> !s_ready)
        else $error("request taken right after a run request");

    a_relax_via_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        relax_we |-> (relax_wvia != '0))
        else $error("improved cost recorded with via vertex zero");

endmodule
